/* design/assert_macros.svh */
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rc4ks_pkg.sv */
package rc4ks_pkg;

	localparam int KEY_MAX_DEF = 256;
	localparam int TBL_DEPTH   = 256;
	localparam int TBL_AW      = 8;
	localparam logic [TBL_AW-1:0] IDX_LAST = 8'hFF;

	// microprogram steps
	typedef enum logic [3:0] {
		P_IDLE, P_FILL, P_KS0, P_KS1, P_KS2, P_KS3, P_DONE,
		P_G0, P_G1, P_G2, P_G3, P_G4
	} step_t;

	// table read address source
	typedef enum logic [2:0] {RD_NONE, RD_N, RD_J_NEXT, RD_I_NEXT, RD_SUM} rd_t;

	// table write address and data source
	typedef enum logic [2:0] {WR_NONE, WR_N_IDX, WR_N_RD, WR_I_RD, WR_J_A} wr_t;

	typedef enum logic [1:0] {J_HOLD, J_CLR, J_KS, J_GEN} j_op_t;
	typedef enum logic [1:0] {I_HOLD, I_CLR, I_INC} i_op_t;
	typedef enum logic [1:0] {K_HOLD, K_CLR, K_STEP} k_op_t;

	// sequencing: fall through, jump, or a conditional jump
	typedef enum logic [2:0] {JC_NEXT, JC_GOTO, JC_DISPATCH, JC_FILL, JC_KSLOOP, JC_OUTWAIT} jc_t;

	typedef struct packed {
		rd_t   rd;
		logic  rd_key;
		wr_t   wr;
		logic  ld_a;
		logic  ld_b;
		logic  ld_fwd;
		logic  ld_out;
		logic  clr_sched;
		logic  ready;
		j_op_t j_op;
		i_op_t i_op;
		logic  n_inc;
		k_op_t k_op;
		jc_t   jc;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic kind;
		logic last;
		logic n_last;
		logic sched;
		logic out_full;
	} status_t;

	// control store
	function automatic ctrl_t ucode(step_t p);
		ctrl_t c;
		c = '0;
		unique case (p)
			P_IDLE: begin
				c.ready = 1'b1;
				c.jc    = JC_DISPATCH;
			end
			P_FILL: begin
				c.wr    = WR_N_IDX;
				c.n_inc = 1'b1;
				c.i_op  = I_CLR;
				c.j_op  = J_CLR;
				c.k_op  = K_CLR;
				c.jc    = JC_FILL;
			end
			P_KS0: begin
				c.rd     = RD_N;
				c.rd_key = 1'b1;
			end
			P_KS1: begin
				c.ld_a = 1'b1;
				c.j_op = J_KS;
				c.rd   = RD_J_NEXT;
			end
			P_KS2: begin
				c.wr = WR_N_RD;
			end
			P_KS3: begin
				c.wr     = WR_J_A;
				c.n_inc  = 1'b1;
				c.k_op   = K_STEP;
				c.jc     = JC_KSLOOP;
				c.target = P_KS0;
			end
			P_DONE: begin
				c.i_op      = I_CLR;
				c.j_op      = J_CLR;
				c.clr_sched = 1'b1;
				c.jc        = JC_GOTO;
				c.target    = P_IDLE;
			end
			P_G0: begin
				c.rd   = RD_I_NEXT;
				c.i_op = I_INC;
			end
			P_G1: begin
				c.ld_a = 1'b1;
				c.j_op = J_GEN;
				c.rd   = RD_J_NEXT;
			end
			P_G2: begin
				c.ld_b = 1'b1;
				c.wr   = WR_I_RD;
			end
			P_G3: begin
				c.wr     = WR_J_A;
				c.rd     = RD_SUM;
				c.ld_fwd = 1'b1;
			end
			P_G4: begin
				c.ld_out = 1'b1;
				c.jc     = JC_OUTWAIT;
				c.target = P_IDLE;
			end
			default: begin
				c.jc     = JC_GOTO;
				c.target = P_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

/* design/arc4_keystream_generator_top.sv */
// Channel  Dir  Group       Contents
// s_       in   key/cmd     tdata key byte, tuser kind, tlast last key byte
// m_       out  keystream   tdata keystream byte
//
// Microcoded sequencer over one 256 x 8 permutation RAM (single read port,
// single write port, registered read); every table access is a program step.
// Generate word: the idle step, four table steps (two dependent reads, two swap
// writes with the output read beside the second), then the load of the output
// register. Key byte: the idle step alone. Last key byte: the idle step, the
// identity fill of all 256 entries, one mixing swap per entry in steps KS0 to
// KS3, and the done step all run before the next word is taken.
// Reset: an identity fill of the table runs first; s_tready is low.
// A result waiting in the output register does not block input; a following
// generate word stalls on its last step until m_tready frees the register.

module arc4_keystream_generator_top #(
	parameter int KEY_MAX = rc4ks_pkg::KEY_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] key_byte
	input  logic [0:0] s_tuser,   // [0] kind
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] keystream_byte
);

	rc4ks_pkg::ctrl_t   ctrl;
	rc4ks_pkg::status_t stat;

	// step counter and control store
	rc4ks_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// table, key store, indices and output register
	rc4ks_dp #(.KEY_MAX(KEY_MAX)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser[0]),
		.in_key    (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// words are taken only on the idle step
	assign s_tready = ctrl.ready;

endmodule

/* design/rc4ks_ram.sv */
module rc4ks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/rc4ks_seq.sv */
`include "assert_macros.svh"

module rc4ks_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  rc4ks_pkg::status_t  stat,
	output rc4ks_pkg::ctrl_t    ctrl
);

	rc4ks_pkg::step_t pc_q;
	rc4ks_pkg::step_t pc_d;

	// control word for the current step
	always_comb begin
		ctrl = rc4ks_pkg::ucode(pc_q);
	end

	// next step
	always_comb begin
		pc_d = rc4ks_pkg::step_t'(pc_q + 4'd1);
		unique case (ctrl.jc)
			rc4ks_pkg::JC_NEXT: begin
				pc_d = rc4ks_pkg::step_t'(pc_q + 4'd1);
			end
			rc4ks_pkg::JC_GOTO: begin
				pc_d = ctrl.target;
			end
			rc4ks_pkg::JC_DISPATCH: begin
				if (stat.accept && stat.kind) begin
					pc_d = rc4ks_pkg::P_G0;
				end else if (stat.accept && stat.last) begin
					pc_d = rc4ks_pkg::P_FILL;
				end else begin
					pc_d = rc4ks_pkg::P_IDLE;
				end
			end
			rc4ks_pkg::JC_FILL: begin
				if (!stat.n_last) begin
					pc_d = rc4ks_pkg::P_FILL;
				end else if (stat.sched) begin
					pc_d = rc4ks_pkg::P_KS0;
				end else begin
					pc_d = rc4ks_pkg::P_IDLE;
				end
			end
			rc4ks_pkg::JC_KSLOOP: begin
				pc_d = stat.n_last ? rc4ks_pkg::P_DONE : ctrl.target;
			end
			rc4ks_pkg::JC_OUTWAIT: begin
				pc_d = stat.out_full ? pc_q : ctrl.target;
			end
			default: begin
				pc_d = rc4ks_pkg::P_IDLE;
			end
		endcase
	end

	// reset starts with the identity fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rc4ks_pkg::P_FILL;
		end else begin
			pc_q <= pc_d;
		end
	end

	`ASSERT_NEXT(a_fill_exit, clk, arst_n, pc_q == rc4ks_pkg::P_FILL && stat.n_last, pc_q == rc4ks_pkg::P_KS0 || pc_q == rc4ks_pkg::P_IDLE, "fill pass left to a wrong step")

endmodule

/* design/rc4ks_dp.sv */
`include "assert_macros.svh"

module rc4ks_dp #(
	parameter int KEY_MAX = rc4ks_pkg::KEY_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rc4ks_pkg::ctrl_t    ctrl,
	output rc4ks_pkg::status_t  stat,
	input  logic                in_valid,
	input  logic                in_kind,
	input  logic [7:0]          in_key,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_data
);

	localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CW = $clog2(KEY_MAX + 1);
	localparam int AW = rc4ks_pkg::TBL_AW;

	logic [AW-1:0] i_q, j_q, n_q, a_q, b_q, out_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] key_cnt_q, key_len_q, k_plus;
	logic          fwd_q, sched_q, out_vld_q;

	logic          accept, key_we;
	logic [AW-1:0] j_next, sum;
	logic          p_we, p_re;
	logic [AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
	logic [7:0]    k_rdata;

	assign accept = in_valid && ctrl.ready;
	assign key_we = accept && !in_kind && (key_cnt_q < CW'(KEY_MAX));
	assign sum    = a_q + b_q;
	assign k_plus = CW'(k_q) + CW'(1);

	always_comb begin
		case (ctrl.j_op)
			rc4ks_pkg::J_KS:  j_next = j_q + p_rdata + k_rdata;
			rc4ks_pkg::J_GEN: j_next = j_q + p_rdata;
			default:          j_next = j_q;
		endcase
	end

	// table port selection
	always_comb begin
		p_re = 1'b1;
		case (ctrl.rd)
			rc4ks_pkg::RD_N:      p_raddr = n_q;
			rc4ks_pkg::RD_J_NEXT: p_raddr = j_next;
			rc4ks_pkg::RD_I_NEXT: p_raddr = i_q + 8'd1;
			rc4ks_pkg::RD_SUM:    p_raddr = sum;
			default: begin
				p_re    = 1'b0;
				p_raddr = n_q;
			end
		endcase
		p_we = 1'b1;
		case (ctrl.wr)
			rc4ks_pkg::WR_N_IDX: begin
				p_waddr = n_q;
				p_wdata = n_q;
			end
			rc4ks_pkg::WR_N_RD: begin
				p_waddr = n_q;
				p_wdata = p_rdata;
			end
			rc4ks_pkg::WR_I_RD: begin
				p_waddr = i_q;
				p_wdata = p_rdata;
			end
			rc4ks_pkg::WR_J_A: begin
				p_waddr = j_q;
				p_wdata = a_q;
			end
			default: begin
				p_we    = 1'b0;
				p_waddr = n_q;
				p_wdata = a_q;
			end
		endcase
	end

	rc4ks_ram #(.WIDTH(8), .DEPTH(rc4ks_pkg::TBL_DEPTH)) u_perm (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	rc4ks_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_cnt_q[KW-1:0]),
		.wdata (in_key),
		.re    (ctrl.rd_key),
		.raddr (k_q),
		.rdata (k_rdata)
	);

	// indices and key bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			key_cnt_q <= '0;
			key_len_q <= '0;
			sched_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (ctrl.i_op)
				rc4ks_pkg::I_CLR: i_q <= '0;
				rc4ks_pkg::I_INC: i_q <= i_q + 8'd1;
				default:          i_q <= i_q;
			endcase
			if (ctrl.j_op == rc4ks_pkg::J_CLR) begin
				j_q <= '0;
			end else begin
				j_q <= j_next;
			end
			if (ctrl.n_inc) begin
				n_q <= n_q + 8'd1;
			end
			case (ctrl.k_op)
				rc4ks_pkg::K_CLR:  k_q <= '0;
				rc4ks_pkg::K_STEP: k_q <= (k_plus == key_len_q) ? '0 : k_plus[KW-1:0];
				default:           k_q <= k_q;
			endcase
			if (accept && !in_kind) begin
				if (in_last) begin
					key_len_q <= key_we ? key_cnt_q + CW'(1) : key_cnt_q;
					key_cnt_q <= '0;
					sched_q   <= 1'b1;
				end else if (key_we) begin
					key_cnt_q <= key_cnt_q + CW'(1);
				end
			end else if (ctrl.clr_sched) begin
				sched_q <= 1'b0;
			end
			if (ctrl.ld_out && !stat.out_full) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// swap operands and result
	always_ff @(posedge clk) begin
		if (ctrl.ld_a) begin
			a_q <= p_rdata;
		end
		if (ctrl.ld_b) begin
			b_q <= p_rdata;
		end
		if (ctrl.ld_fwd) begin
			fwd_q <= (sum == j_q);
		end
		if (ctrl.ld_out && !stat.out_full) begin
			out_q <= fwd_q ? a_q : p_rdata;
		end
	end

	always_comb begin
		stat.accept   = accept;
		stat.kind     = in_kind;
		stat.last     = in_last;
		stat.n_last   = (n_q == rc4ks_pkg::IDX_LAST);
		stat.sched    = sched_q;
		stat.out_full = out_vld_q && !out_ready;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`ASSERT_IMPL(a_no_overrun, clk, arst_n, ctrl.ld_out && out_vld_q && !out_ready, !p_re && !p_we, "result step moved on while output held")
	`ASSERT_IMPL(a_len_nonzero, clk, arst_n, sched_q, key_len_q != '0, "schedule pending with empty key")

endmodule

/* tb/tb_arc4_keystream_generator_top.sv */
module tb_arc4_keystream_generator_top;

	// kind field of an input word, carried on s_tuser
	typedef enum bit {KIND_KEY = 1'b0, KIND_GEN = 1'b1} word_kind_t;

	localparam int TIMEOUT = 10_000_000;   // far above the slowest legal run
	localparam int TAIL_CYCLES = 1300;     // covers one full key schedule plus a generate
	localparam int PHASE_WORDS = 100;

	// Keystream predictor and checker: own copy of the permutation, indices and
	// key store; expected bytes queue up in order of acceptance.
	class arc4_keystream_tracker;
		bit [7:0] perm_tbl[rc4ks_pkg::TBL_DEPTH];
		bit [7:0] key_mem[rc4ks_pkg::KEY_MAX_DEF];
		bit [7:0] i_idx, j_idx;
		bit [8:0] key_len;
		bit [7:0] ks_pending[$];
		int       mismatches;
		int       matched;
		int       schedules;
		int       longest_key;

		function new();
			for (int n = 0; n < rc4ks_pkg::TBL_DEPTH; n++)
				perm_tbl[n] = n[7:0];
			i_idx = '0;
			j_idx = '0;
			key_len = '0;
		endfunction

		function void rekey(int len);
			bit [7:0] a, j;
			int k;
			j = '0;
			k = 0;
			for (int n = 0; n < rc4ks_pkg::TBL_DEPTH; n++)
				perm_tbl[n] = n[7:0];
			for (int n = 0; n < rc4ks_pkg::TBL_DEPTH; n++) begin
				a = perm_tbl[n];
				j = j + a + key_mem[k];
				perm_tbl[n] = perm_tbl[j];
				perm_tbl[j] = a;
				k++;
				if (k >= len)
					k = 0;
			end
			i_idx = '0;
			j_idx = '0;
			schedules++;
			if (len > longest_key)
				longest_key = len;
		endfunction

		// word accepted on the slave side
		function void take_word(word_kind_t kind, bit [7:0] kb, bit last);
			bit [7:0] a, b;
			if (kind == KIND_KEY) begin
				// bytes past KEY_MAX are dropped, count saturates
				if (key_len < rc4ks_pkg::KEY_MAX_DEF) begin
					key_mem[key_len] = kb;
					key_len++;
				end
				if (last) begin
					rekey(key_len);
					key_len = '0;
				end
			end else begin
				i_idx = i_idx + 8'd1;
				a = perm_tbl[i_idx];
				j_idx = j_idx + a;
				b = perm_tbl[j_idx];
				perm_tbl[i_idx] = b;
				perm_tbl[j_idx] = a;
				ks_pending.push_back(perm_tbl[8'(a + b)]);
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t: mismatch: %s", $time, msg);
		endtask

		// word accepted on the master side
		task check_byte(bit [7:0] got);
			bit [7:0] want;
			if (ks_pending.size() == 0) begin
				report_mismatch($sformatf("keystream byte %02h with none expected", got));
			end else begin
				want = ks_pending.pop_front();
				if (got !== want)
					report_mismatch($sformatf("keystream_byte got %02h want %02h", got, want));
				else
					matched++;
			end
		endtask

		function int outstanding();
			return ks_pending.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;      // [7:0] key_byte
	logic [0:0] s_tuser = '0;      // [0] kind
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] keystream_byte

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int phase_words = 0;

	arc4_keystream_tracker ks_track = new();

	arc4_keystream_generator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// both handshakes sampled at the rising edge, before any register updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				ks_track.take_word(word_kind_t'(s_tuser[0]), s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				ks_track.check_byte(m_tdata);
		end
	end

	// One word on the slave side. Called and returns at a falling edge.
	task send_word(word_kind_t kind, bit [7:0] kb, bit last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tuser[0] <= kind;
		s_tdata    <= kb;
		s_tlast    <= last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		words_sent++;
		phase_words++;
	endtask

	// generate words carry random, ignored key_byte and last
	task send_gens(int count);
		repeat (count)
			send_word(KIND_GEN, 8'($urandom), 1'($urandom));
	endtask

	// key bytes of random content; last set on the final one if asked
	task send_key(int len, bit finish);
		for (int n = 0; n < len; n++)
			send_word(KIND_KEY, 8'($urandom), finish && (n == len - 1));
	endtask

	// hold the sender until every outstanding keystream byte is out
	task drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (ks_track.outstanding() != 0)
			@(negedge clk);
	endtask

	// one stimulus sequence: mostly well-formed key-then-keystream runs
	task run_sequence();
		int pick, len, cut;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			send_key(len, 1'b1);
			send_gens($urandom_range(1, 30));
		end else if (pick < 82) begin
			// keystream requested while a key is half loaded
			len = $urandom_range(2, 20);
			cut = $urandom_range(1, len - 1);
			send_key(cut, 1'b0);
			send_gens($urandom_range(1, 8));
			send_key(len - cut, 1'b1);
			send_gens($urandom_range(1, 20));
		end else if (pick < 97) begin
			// noise: any mix of kinds and last marks
			repeat ($urandom_range(1, 8))
				send_word(word_kind_t'(1'($urandom)), 8'($urandom), ($urandom_range(0, 3) == 0));
		end else begin
			// full-length or overlong key
			send_key($urandom_range(rc4ks_pkg::KEY_MAX_DEF, rc4ks_pkg::KEY_MAX_DEF + 4), 1'b1);
			send_gens($urandom_range(5, 20));
		end
	endtask

	task run_phase(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		phase_words = 0;
		while (phase_words < PHASE_WORDS)
			run_sequence();
		drain();
	endtask

	initial begin
		#TIMEOUT;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: keystream straight from the reset permutation, with the
		// ignored fields at their extremes
		send_word(KIND_GEN, 8'hFF, 1'b1);
		send_word(KIND_GEN, 8'h00, 1'b0);
		send_word(KIND_GEN, 8'hA5, 1'b1);
		// one-byte key of zero
		send_word(KIND_KEY, 8'h00, 1'b1);
		send_gens(3);
		// keystream in the middle of loading a key; partial key kept
		send_word(KIND_KEY, 8'hFF, 1'b0);
		send_gens(2);
		send_word(KIND_KEY, 8'h80, 1'b0);
		send_word(KIND_KEY, 8'h01, 1'b1);
		send_gens(3);
		// all-ones key, two bytes
		send_word(KIND_KEY, 8'hFF, 1'b0);
		send_word(KIND_KEY, 8'hFF, 1'b1);
		send_gens(4);
		drain();

		// overlong key: mark sits on a dropped byte
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_key(rc4ks_pkg::KEY_MAX_DEF + 1, 1'b1);
		send_gens(6);
		drain();

		run_phase(0, 0);
		run_phase(87, 0);
		run_phase(0, 87);
		run_phase(34, 34);
		run_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (ks_track.outstanding() != 0)
			ks_track.report_mismatch($sformatf("%0d keystream bytes never arrived",
				ks_track.outstanding()));

		$display("Sent %0d words; %0d keystream bytes matched over %0d key schedules,",
			words_sent, ks_track.matched, ks_track.schedules);
		$display("longest key %0d bytes, idle and stall mixes from none to 87 percent.",
			ks_track.longest_key);
		if (ks_track.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/rc4ks_pkg.sv
design/rc4ks_ram.sv
design/rc4ks_seq.sv
design/rc4ks_dp.sv
design/arc4_keystream_generator_top.sv
tb/tb_arc4_keystream_generator_top.sv
